>>> rtl/assert_macros.svh
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check an implication on every clock edge outside reset.
`define FFLA_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("allocator assertion failed");
// Check that a condition never holds outside reset.
`define FFLA_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("allocator forbidden condition seen");
`else
`define FFLA_ASSERT(label, clk, rstn, prop)
`define FFLA_NEVER(label, clk, rstn, cond)
`endif
`endif

>>> rtl/ffla_pkg.sv
// Types and constants of the free-list allocator.
package ffla_pkg;

    localparam int MAX_BLOCKS = 4096;
    localparam int BLK_W      = $clog2(MAX_BLOCKS);
    localparam int ENTRY_W    = BLK_W + 1;
    localparam int CFG_W      = 13;

    localparam logic [ENTRY_W-1:0] END_MARK   = {1'b1, {BLK_W{1'b0}}};
    localparam logic [BLK_W-1:0]   BLK_MAX    = {BLK_W{1'b1}};
    localparam logic [CFG_W-1:0]   RESET_BLOCKS = CFG_W'(1024);
    localparam logic [CFG_W-1:0]   CFG_CAP      = CFG_W'(MAX_BLOCKS);

    // Request kinds
    localparam logic [2:0] KIND_ALLOC  = 3'd0;
    localparam logic [2:0] KIND_FREE   = 3'd1;
    localparam logic [2:0] KIND_LINK   = 3'd2;
    localparam logic [2:0] KIND_READ   = 3'd3;
    localparam logic [2:0] KIND_TAIL   = 3'd4;
    localparam logic [2:0] KIND_FORMAT = 3'd5;

    typedef struct packed {
        logic [2:0]       kind;
        logic [BLK_W-1:0] block_index;
        logic [BLK_W-1:0] link_target;
        logic             link_is_end;
    } req_t;

    typedef struct packed {
        logic             status;
        logic [BLK_W-1:0] result_block;
        logic             result_is_end;
        logic [BLK_W-1:0] free_left;
    } rsp_t;

    typedef struct packed {
        logic               re;
        logic [BLK_W-1:0]   raddr;
        logic               we;
        logic [BLK_W-1:0]   waddr;
        logic [ENTRY_W-1:0] wdata;
    } ram_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WALK,
        ST_SWEEP,
        ST_RESP
    } state_t;

endpackage

>>> rtl/ffla_table_ram.sv
// Single-port-read, single-port-write chain table memory with registered read.
module ffla_table_ram #(
    parameter int ADDR_W = 12,
    parameter int DATA_W = 13
) (
    input  logic              aclk,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, held while not enabled
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/ffla_ctrl.sv
// Request sequencer: free-list head and count, table read-modify-write, walk and format.
`include "assert_macros.svh"
module ffla_ctrl import ffla_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  req_t               s_data,
    input  logic [CFG_W-1:0]   blocks_in_use,
    input  logic               out_free,
    output logic               out_load,
    output rsp_t               out_rsp,
    output ram_req_t           ram_req,
    input  logic [ENTRY_W-1:0] ram_rdata
);

    state_t           state_reg, state_next;
    req_t             req_reg, req_next;
    logic [BLK_W-1:0] head_reg, head_next;
    logic [BLK_W-1:0] count_reg, count_next;
    logic [BLK_W-1:0] ptr_reg, ptr_next;
    logic [BLK_W-1:0] steps_reg, steps_next;
    logic [BLK_W-1:0] last_reg, last_next;
    logic             reply_reg, reply_next;
    logic [BLK_W-1:0] res_block_reg, res_block_next;
    logic             res_end_reg, res_end_next;
    logic [BLK_W-1:0] cfg_last;
    logic             accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // Clamp the formatted size to 2..MAX_BLOCKS and take the last index
    always_comb begin
        if (blocks_in_use < CFG_W'(2)) begin
            cfg_last = BLK_W'(1);
        end else if (blocks_in_use >= CFG_CAP) begin
            cfg_last = BLK_MAX;
        end else begin
            cfg_last = BLK_W'(blocks_in_use - CFG_W'(1));
        end
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_SWEEP;
            head_reg  <= BLK_W'(1);
            count_reg <= BLK_W'(RESET_BLOCKS - CFG_W'(1));
            ptr_reg   <= '0;
            last_reg  <= BLK_W'(RESET_BLOCKS - CFG_W'(1));
            reply_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
            last_reg  <= last_next;
            reply_reg <= reply_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        req_reg       <= req_next;
        steps_reg     <= steps_next;
        res_block_reg <= res_block_next;
        res_end_reg   <= res_end_next;
    end

    // Next state, table accesses and result
    always_comb begin
        state_next     = state_reg;
        req_next       = req_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        steps_next     = steps_reg;
        last_next      = last_reg;
        reply_next     = reply_reg;
        res_block_next = res_block_reg;
        res_end_next   = res_end_reg;
        ram_req        = '0;
        out_load       = 1'b0;
        out_rsp        = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    req_next = s_data;
                    // Issue the entry read for this request
                    ram_req.re    = 1'b1;
                    ram_req.raddr = (s_data.kind == KIND_ALLOC) ? head_reg
                                                                : s_data.block_index;
                    if (s_data.kind == KIND_TAIL) begin
                        ptr_next   = s_data.block_index;
                        steps_next = '0;
                        state_next = ST_WALK;
                    end else if (s_data.kind == KIND_FORMAT) begin
                        ptr_next       = '0;
                        last_next      = cfg_last;
                        head_next      = BLK_W'(1);
                        count_next     = cfg_last;
                        reply_next     = 1'b1;
                        res_block_next = '0;
                        res_end_next   = 1'b0;
                        state_next     = ST_SWEEP;
                    end else begin
                        state_next = ST_EXEC;
                    end
                end
            end

            ST_EXEC: begin
                // Apply the update together with the result beat
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                    if (req_reg.kind == KIND_ALLOC) begin
                        if (count_reg == '0) begin
                            out_rsp.status = 1'b1;
                        end else begin
                            head_next            = ram_rdata[BLK_W-1:0];
                            count_next           = count_reg - BLK_W'(1);
                            ram_req.we           = 1'b1;
                            ram_req.waddr        = head_reg;
                            ram_req.wdata        = END_MARK;
                            out_rsp.result_block = head_reg;
                        end
                    end else if (req_reg.kind == KIND_FREE) begin
                        ram_req.we    = 1'b1;
                        ram_req.waddr = req_reg.block_index;
                        ram_req.wdata = (count_reg == '0) ? END_MARK : {1'b0, head_reg};
                        head_next     = req_reg.block_index;
                        if (count_reg != BLK_MAX) begin
                            count_next = count_reg + BLK_W'(1);
                        end
                    end else if (req_reg.kind == KIND_LINK) begin
                        ram_req.we    = 1'b1;
                        ram_req.waddr = req_reg.block_index;
                        ram_req.wdata = req_reg.link_is_end ? END_MARK
                                                            : {1'b0, req_reg.link_target};
                    end else if (req_reg.kind == KIND_READ) begin
                        out_rsp.result_is_end = ram_rdata[BLK_W];
                        out_rsp.result_block  = ram_rdata[BLK_W] ? '0
                                                                 : ram_rdata[BLK_W-1:0];
                    end
                    out_rsp.free_left = count_next;
                end
            end

            ST_WALK: begin
                // Follow one link per cycle straight from the read data
                if (ram_rdata[BLK_W]) begin
                    res_block_next = ptr_reg;
                    res_end_next   = 1'b1;
                    state_next     = ST_RESP;
                end else if (steps_reg == BLK_MAX) begin
                    res_block_next = ram_rdata[BLK_W-1:0];
                    res_end_next   = 1'b0;
                    state_next     = ST_RESP;
                end else begin
                    ptr_next      = ram_rdata[BLK_W-1:0];
                    steps_next    = steps_reg + BLK_W'(1);
                    ram_req.re    = 1'b1;
                    ram_req.raddr = ram_rdata[BLK_W-1:0];
                end
            end

            ST_SWEEP: begin
                // Write one table entry per cycle
                ram_req.we    = 1'b1;
                ram_req.waddr = ptr_reg;
                if (ptr_reg == '0 || ptr_reg == last_reg) begin
                    ram_req.wdata = END_MARK;
                end else if (ptr_reg < last_reg) begin
                    ram_req.wdata = {1'b0, ptr_reg + BLK_W'(1)};
                end else begin
                    ram_req.wdata = '0;
                end
                ptr_next = ptr_reg + BLK_W'(1);
                if (ptr_reg == BLK_MAX) begin
                    state_next = reply_reg ? ST_RESP : ST_IDLE;
                end
            end

            ST_RESP: begin
                // Hold the finished result until the output slot frees
                if (out_free) begin
                    out_load              = 1'b1;
                    out_rsp.result_block  = res_block_reg;
                    out_rsp.result_is_end = res_end_reg;
                    out_rsp.free_left     = count_reg;
                    state_next            = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `FFLA_NEVER(a_walk_no_write, aclk, aresetn, (state_reg == ST_WALK) && ram_req.we)
    `FFLA_ASSERT(a_load_source, aclk, aresetn,
        out_load |-> (state_reg == ST_EXEC || state_reg == ST_RESP))
    `FFLA_ASSERT(a_empty_alloc, aclk, aresetn,
        (out_load && state_reg == ST_EXEC && req_reg.kind == KIND_ALLOC &&
         count_reg == '0) |-> (out_rsp.status && !ram_req.we))
    `FFLA_ASSERT(a_alloc_pop, aclk, aresetn,
        (out_load && state_reg == ST_EXEC && req_reg.kind == KIND_ALLOC &&
         count_reg != '0) |=> (count_reg == $past(count_reg) - BLK_W'(1)))

endmodule

>>> rtl/fat_free_list_allocator_top.sv
// Top level of the free-list allocator: config register, output stage, table memory.
//
// FAT-style chain table of 4096 entries with a free list, kept in one synchronous
// table RAM (one read and one write port, registered read). Allocate, free, link,
// read-next and the unused kinds read the entry in the accept cycle; the write-back
// and the result beat follow together once the output slot is free.
// Find-tail follows one link per cycle through the RAM read port. Format sweeps
// the whole table one entry per cycle through the write port. After reset the
// block runs the same sweep with blocks_in_use = 1024 and holds s_ready low
// until it ends; configuration writes are taken at any time.
`include "assert_macros.svh"
module fat_free_list_allocator_top import ffla_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  req_t             s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output rsp_t             m_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data
);

    logic [CFG_W-1:0]   blocks_reg, blocks_next;
    logic               m_valid_reg, m_valid_next;
    rsp_t               m_data_reg, m_data_next;
    logic               out_free;
    logic               out_load;
    rsp_t               out_rsp;
    ram_req_t           ram_req;
    logic [ENTRY_W-1:0] ram_rdata;

    // Configuration register
    assign cfg_ready   = 1'b1;
    assign blocks_next = (cfg_valid && cfg_ready) ? cfg_data : blocks_reg;

    // Output register: load when empty or being drained
    assign out_free     = !m_valid_reg || m_ready;
    assign m_valid_next = out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    assign m_data_next  = out_load ? out_rsp : m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blocks_reg  <= RESET_BLOCKS;
            m_valid_reg <= 1'b0;
        end else begin
            blocks_reg  <= blocks_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    ffla_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .blocks_in_use (blocks_reg),
        .out_free      (out_free),
        .out_load      (out_load),
        .out_rsp       (out_rsp),
        .ram_req       (ram_req),
        .ram_rdata     (ram_rdata)
    );

    ffla_table_ram #(
        .ADDR_W (BLK_W),
        .DATA_W (ENTRY_W)
    ) u_table (
        .aclk  (aclk),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata)
    );

    `FFLA_ASSERT(a_load_when_free, aclk, aresetn, out_load |-> out_free)

endmodule

>>> sim/fat_free_list_allocator_top_tb.sv
// Self-checking testbench for the free-list allocator top level.
`timescale 1ns / 100ps

module fat_free_list_allocator_top_tb;
    import ffla_pkg::*;

    // Kinds the block must answer with a beat that carries only the free count
    localparam logic [2:0] KIND_SPARE6 = 3'd6;
    localparam logic [2:0] KIND_SPARE7 = 3'd7;

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    req_t             s_data;
    logic             m_valid;
    logic             m_ready;
    rsp_t             m_data;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data;

    // Shadow of the chain table, free list and format size
    logic [ENTRY_W-1:0] chain_img [MAX_BLOCKS];
    logic [BLK_W-1:0]   head_img;
    logic [BLK_W-1:0]   count_img;
    logic [CFG_W-1:0]   blocks_img;

    rsp_t             rsp_due[$];
    logic [BLK_W-1:0] owned[$];
    int               errors = 0;
    bit               quiet = 1'b0;
    bit               stall_req = 1'b0;

    fat_free_list_allocator_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Rebuild the shadow table the way a format sweep leaves it
    function automatic void format_chain();
        int b;
        b = int'(blocks_img);
        if (b > MAX_BLOCKS) b = MAX_BLOCKS;
        if (b < 2) b = 2;
        for (int i = 0; i < MAX_BLOCKS; i++) begin
            if (i == 0 || i == b - 1) chain_img[i] = END_MARK;
            else if (i < b - 1) chain_img[i] = ENTRY_W'(i + 1);
            else chain_img[i] = '0;
        end
        head_img  = BLK_W'(1);
        count_img = BLK_W'(b - 1);
    endfunction

    // Apply one request to the shadow state and return the beat it must produce
    function automatic rsp_t chain_step(req_t r);
        rsp_t               o;
        logic [ENTRY_W-1:0] e;
        logic [BLK_W-1:0]   cur;
        int                 steps;
        bit                 found;
        o = '0;
        case (r.kind)
            KIND_ALLOC: begin
                if (count_img == '0) begin
                    o.status = 1'b1;
                end else begin
                    o.result_block = head_img;
                    e = chain_img[head_img];
                    chain_img[head_img] = END_MARK;
                    head_img  = e[BLK_W-1:0];
                    count_img = count_img - BLK_W'(1);
                end
            end
            KIND_FREE: begin
                chain_img[r.block_index] = (count_img == '0) ? END_MARK : {1'b0, head_img};
                head_img = r.block_index;
                if (count_img != BLK_MAX) count_img = count_img + BLK_W'(1);
            end
            KIND_LINK: begin
                chain_img[r.block_index] = r.link_is_end ? END_MARK : {1'b0, r.link_target};
            end
            KIND_READ: begin
                e = chain_img[r.block_index];
                o.result_is_end = e[BLK_W];
                o.result_block  = e[BLK_W] ? '0 : e[BLK_W-1:0];
            end
            KIND_TAIL: begin
                // Follow links until an end mark, giving up after a full table of steps
                cur   = r.block_index;
                steps = 0;
                found = 1'b0;
                while (!found && steps < MAX_BLOCKS) begin
                    if (chain_img[cur][BLK_W]) begin
                        found = 1'b1;
                    end else begin
                        cur = chain_img[cur][BLK_W-1:0];
                        steps++;
                    end
                end
                o.result_is_end = found;
                o.result_block  = cur;
            end
            KIND_FORMAT: begin
                format_chain();
            end
            default: begin
            end
        endcase
        o.free_left = count_img;
        return o;
    endfunction

    function automatic req_t mk(logic [2:0] kind, logic [BLK_W-1:0] blk,
                                logic [BLK_W-1:0] tgt, logic lend);
        req_t r;
        r.kind        = kind;
        r.block_index = blk;
        r.link_target = tgt;
        r.link_is_end = lend;
        return r;
    endfunction

    function automatic void check_field(string name, logic [BLK_W-1:0] want,
                                        logic [BLK_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // Compare every result beat against the oldest outstanding prediction
    always @(posedge aclk) begin : check_results
        rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (rsp_due.size() == 0) begin
                $error("result beat with no request outstanding");
                errors++;
            end else begin
                want = rsp_due.pop_front();
                check_field("status", BLK_W'(want.status), BLK_W'(m_data.status));
                check_field("result_block", want.result_block, m_data.result_block);
                check_field("result_is_end", BLK_W'(want.result_is_end),
                            BLK_W'(m_data.result_is_end));
                check_field("free_left", want.free_left, m_data.free_left);
            end
        end
    end

    // Drive m_ready: random holds, one long hold on request, none when quiet
    initial begin : drive_ready
        int n;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_req) begin
                m_ready <= 1'b0;
                repeat (60) @(negedge aclk);
                stall_req = 1'b0;
                m_ready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                n = $urandom_range(1, 5);
                repeat (n) @(negedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Offer one request beat, hold it until taken, then record its prediction
    task automatic send_req(input req_t r, output rsp_t want);
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= r;
        do @(posedge aclk); while (!s_ready);
        want = chain_step(r);
        rsp_due.push_back(want);
    endtask

    task automatic sender_gap();
        int n;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 5);
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (n - 1) @(negedge aclk);
        end
    endtask

    task automatic issue(input req_t r);
        rsp_t want;
        send_req(r, want);
        sender_gap();
    endtask

    task automatic release_request();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    // Write the format size once every outstanding result has drained
    task automatic write_blocks_in_use(input logic [CFG_W-1:0] v);
        release_request();
        while (rsp_due.size() != 0) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        blocks_img = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [BLK_W-1:0] take_owned(bit remove);
        int               i;
        logic [BLK_W-1:0] b;
        i = $urandom_range(0, owned.size() - 1);
        b = owned[i];
        if (remove) owned.delete(i);
        return b;
    endfunction

    // Mostly well-formed traffic on allocated blocks, with some random noise
    function automatic req_t pick_request();
        req_t r;
        int   sel;
        r.kind        = KIND_READ;
        r.block_index = BLK_W'($urandom_range(0, MAX_BLOCKS - 1));
        r.link_target = BLK_W'($urandom_range(0, MAX_BLOCKS - 1));
        r.link_is_end = 1'($urandom_range(0, 1));
        sel = $urandom_range(0, 99);
        if (sel < 35) begin
            r.kind = KIND_ALLOC;
        end else if (sel < 60) begin
            r.kind = KIND_FREE;
            if (owned.size() != 0 && sel < 55) r.block_index = take_owned(1'b1);
        end else if (sel < 75) begin
            r.kind = KIND_LINK;
            if (owned.size() >= 2 && sel < 72) begin
                r.block_index = take_owned(1'b0);
                r.link_target = take_owned(1'b0);
                r.link_is_end = ($urandom_range(0, 3) == 0);
            end
        end else if (sel < 90) begin
            r.kind = KIND_READ;
            if (owned.size() != 0 && sel < 83) r.block_index = take_owned(1'b0);
        end else if (sel < 97) begin
            r.kind = KIND_TAIL;
            if (owned.size() != 0 && sel < 96) r.block_index = take_owned(1'b0);
        end else if (sel == 97) begin
            r.kind = KIND_FORMAT;
            owned.delete();
        end else begin
            r.kind = (sel == 98) ? KIND_SPARE6 : KIND_SPARE7;
        end
        return r;
    endfunction

    // Table as left by the sweep after reset, plus the unused kinds
    task automatic test_reset_table();
        issue(mk(KIND_READ, 12'd0, 12'd0, 1'b0));
        issue(mk(KIND_READ, 12'd1, 12'd0, 1'b0));
        issue(mk(KIND_READ, 12'd1023, 12'd0, 1'b0));
        issue(mk(KIND_READ, BLK_MAX, BLK_MAX, 1'b1));
        issue(mk(KIND_ALLOC, 12'd0, 12'd0, 1'b0));
        issue(mk(KIND_FREE, BLK_MAX, 12'd0, 1'b0));
        issue(mk(KIND_TAIL, BLK_MAX, 12'd0, 1'b0));
        issue(mk(KIND_SPARE6, BLK_MAX, BLK_MAX, 1'b1));
        issue(mk(KIND_SPARE7, 12'd0, 12'd0, 1'b0));
    endtask

    // Smallest table: empty pops, free onto an empty list, a self-looping chain
    task automatic test_tiny_table();
        write_blocks_in_use(13'd0);
        issue(mk(KIND_FORMAT, BLK_MAX, BLK_MAX, 1'b1));
        issue(mk(KIND_ALLOC, 12'd0, 12'd0, 1'b0));
        issue(mk(KIND_ALLOC, 12'd0, 12'd0, 1'b0));
        issue(mk(KIND_FREE, 12'd7, 12'd0, 1'b0));
        issue(mk(KIND_READ, 12'd7, 12'd0, 1'b0));
        issue(mk(KIND_ALLOC, 12'd0, 12'd0, 1'b0));
        issue(mk(KIND_LINK, 12'd7, BLK_MAX, 1'b0));
        issue(mk(KIND_LINK, BLK_MAX, BLK_MAX, 1'b0));
        issue(mk(KIND_TAIL, 12'd7, 12'd0, 1'b0));
        issue(mk(KIND_LINK, 12'd7, 12'h555, 1'b1));
        issue(mk(KIND_READ, 12'd7, 12'd0, 1'b0));
    endtask

    // Largest table: full count saturates on free, longest clean walk
    task automatic test_saturated_count();
        write_blocks_in_use(13'h1FFF);
        issue(mk(KIND_FORMAT, 12'd0, 12'd0, 1'b0));
        issue(mk(KIND_FREE, 12'd0, 12'd0, 1'b0));
        issue(mk(KIND_READ, BLK_MAX, 12'd0, 1'b0));
        issue(mk(KIND_TAIL, 12'd0, 12'd0, 1'b0));
    endtask

    // Hold off the result side while requests keep coming, so the input stalls
    task automatic test_output_stall();
        rsp_t want;
        stall_req = 1'b1;
        repeat (16) begin
            send_req(mk(($urandom_range(0, 1) != 0) ? KIND_ALLOC : KIND_READ,
                        BLK_W'($urandom_range(0, MAX_BLOCKS - 1)), 12'd0, 1'b0), want);
        end
    endtask

    task automatic test_random_traffic(input logic [CFG_W-1:0] size, input int count);
        req_t r;
        rsp_t want;
        write_blocks_in_use(size);
        owned.delete();
        issue(mk(KIND_FORMAT, BLK_W'($urandom_range(0, MAX_BLOCKS - 1)), 12'd0, 1'b0));
        repeat (count) begin
            r = pick_request();
            send_req(r, want);
            if (r.kind == KIND_ALLOC && !want.status) owned.push_back(want.result_block);
            sender_gap();
        end
    endtask

    initial begin : run
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        blocks_img = RESET_BLOCKS;
        format_chain();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_table();
        test_tiny_table();
        test_saturated_count();
        test_output_stall();
        test_random_traffic(13'd0, 150);
        test_random_traffic(13'd16, 200);
        test_random_traffic(13'd256, 200);
        test_random_traffic(13'd4096, 200);
        test_random_traffic(13'h1FFF, 150);
        test_random_traffic(13'd2, 100);
        // Run the last phase with no idling on either side
        quiet = 1'b1;
        test_random_traffic(RESET_BLOCKS, 250);

        // Drain, then watch a little longer for stray beats
        release_request();
        while (rsp_due.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin : watchdog
        #40_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
